FILE: src/sha1_pkg.sv
package sha1_pkg;

	localparam int NUM_WORDS  = 5;
	localparam int BLK_BYTES  = 64;
	localparam int BLK_WORDS  = 16;
	localparam int ROUNDS     = 80;
	localparam int LEN_OFFSET = 56;

	typedef logic [31:0] word_t;
	typedef logic [NUM_WORDS-1:0][31:0] chain_t;

	localparam chain_t IV = {
		32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};

	localparam logic [3:0][31:0] K = {
		32'hca62c1d6, 32'h8f1bbcdc, 32'h6ed9eba1, 32'h5a827999
	};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [2:0] LAST_IDX = 3'd4;

	typedef struct packed {
		logic start;
		logic restart;
	} core_ctl_t;

	typedef struct packed {
		logic   busy;
		chain_t chain;
	} core_sts_t;

endpackage

FILE: src/sha1_buf.sv
module sha1_buf
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        wr_en,
	input  logic [5:0]  wr_idx,
	input  logic [7:0]  wr_byte,
	input  logic [3:0]  rd_addr,
	output word_t       rd_data
);

	word_t mem_q [BLK_WORDS];
	word_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx[5:2]][{~wr_idx[1:0], 3'b000} +: 8] <= wr_byte;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

FILE: src/sha1_core.sv
module sha1_core
	import sha1_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  core_ctl_t  ctl,
	output core_sts_t  sts,
	output logic [3:0] rd_addr,
	input  word_t      rd_data
);

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_LOAD = 2'd1;
	localparam logic [1:0] C_RUN  = 2'd2;
	localparam logic [1:0] C_FIN  = 2'd3;

	localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);

	logic [1:0] state_q;
	logic [6:0] round_q;
	chain_t     chain_q;
	word_t      a_q, b_q, c_q, d_q, e_q;
	word_t      sh_q [BLK_WORDS];
	word_t      w, f, k, t, mix;

	always_comb begin
		mix = sh_q[13] ^ sh_q[8] ^ sh_q[2] ^ sh_q[0];
		w   = (round_q < 7'(BLK_WORDS)) ? rd_data : {mix[30:0], mix[31]};
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K[0];
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K[1];
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K[2];
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K[3];
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w;
	end

	assign rd_addr   = (state_q == C_LOAD) ? 4'd0 : round_q[3:0] + 4'd1;
	assign sts.busy  = (state_q != C_IDLE);
	assign sts.chain = chain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			round_q <= '0;
			chain_q <= IV;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (ctl.restart) chain_q <= IV;
					if (ctl.start) state_q <= C_LOAD;
				end
				C_LOAD: begin
					round_q <= '0;
					state_q <= C_RUN;
				end
				C_RUN: begin
					round_q <= round_q + 7'd1;
					if (round_q == LAST_ROUND) state_q <= C_FIN;
				end
				C_FIN: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					state_q    <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && ctl.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == C_RUN) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < BLK_WORDS - 1; i++) begin
				sh_q[i] <= sh_q[i+1];
			end
			sh_q[BLK_WORDS-1] <= w;
		end
	end

endmodule

FILE: src/sha1_stream_hasher_top.sv
// One input beat per cycle while a block fills; a full block stalls input for
// the one-word read ahead, 80 rounds of the shared round unit and the chain add.
// Message end: padding goes in one byte per cycle outside compressions, then one
// or two compressions, then five digest beats, one per cycle with m_tready high.
// Asynchronous reset clears the sequencer and counts and loads the initial hash;
// block buffer contents stay undefined until written.
module sha1_stream_hasher_top
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [0:0]  s_tuser,   // byte_valid
	input  logic        s_tlast,   // message_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // digest_word
	output logic [2:0]  m_tuser,   // word_index
	output logic        m_tlast    // last_word
);

	localparam logic [1:0] S_IN   = 2'd0;
	localparam logic [1:0] S_PAD  = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	localparam logic [5:0] LAST_FILL = 6'(BLK_BYTES - 1);
	localparam logic [5:0] LEN_FILL  = 6'(LEN_OFFSET);

	logic [1:0]  state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic        mark_q, wrap_q, pad_q, final_q;
	logic [2:0]  idx_q;

	logic        acc, wr_en, blk_full;
	logic [7:0]  wr_byte, pad_byte;
	logic [3:0]  rd_addr;
	word_t       rd_data;
	core_ctl_t   ctl;
	core_sts_t   sts;

	assign s_tready = (state_q == S_IN);
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (fill_q >= LEN_FILL && !wrap_q) begin
			pad_byte = bits_q[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'd0;
		end
		wr_en   = (acc && s_tuser[0]) || (state_q == S_PAD);
		wr_byte = (state_q == S_PAD) ? pad_byte : s_tdata;
	end

	assign blk_full    = wr_en && (fill_q == LAST_FILL);
	assign ctl.start   = blk_full;
	assign ctl.restart = (state_q == S_OUT) && m_tready && (idx_q == LAST_IDX);

	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = sts.chain[idx_q];
	assign m_tuser  = idx_q;
	assign m_tlast  = (idx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IN;
			fill_q  <= '0;
			bits_q  <= '0;
			mark_q  <= 1'b0;
			wrap_q  <= 1'b0;
			pad_q   <= 1'b0;
			final_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IN: begin
					if (acc) begin
						if (s_tuser[0]) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
						end
						if (blk_full) begin
							state_q <= S_WAIT;
							pad_q   <= s_tlast;
							final_q <= 1'b0;
						end else if (s_tlast) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (!mark_q) begin
						mark_q <= 1'b1;
						if (fill_q >= LEN_FILL && fill_q != LAST_FILL) wrap_q <= 1'b1;
					end
					if (blk_full) begin
						state_q <= S_WAIT;
						pad_q   <= 1'b1;
						final_q <= mark_q && !wrap_q;
						if (mark_q) wrap_q <= 1'b0;
					end
				end
				S_WAIT: begin
					idx_q <= '0;
					if (!sts.busy) begin
						if (final_q) state_q <= S_OUT;
						else if (pad_q) state_q <= S_PAD;
						else state_q <= S_IN;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == LAST_IDX) begin
							state_q <= S_IN;
							fill_q  <= '0;
							bits_q  <= '0;
							mark_q  <= 1'b0;
							wrap_q  <= 1'b0;
							pad_q   <= 1'b0;
							final_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_IN;
			endcase
		end
	end

	sha1_buf u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_idx  (fill_q),
		.wr_byte (wr_byte),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sha1_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.sts     (sts),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule
